FILE: sv/tcl_pkg.sv
// Shared constants and types for the two-way cache lookup block.
`default_nettype none
package tcl_pkg;

  localparam int NUM_SETS  = 4;
  localparam int NUM_WAYS  = 2;
  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 8;

  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
  localparam int LINE_BITS = SET_BITS + WAY_BITS;
  localparam int NUM_LINES = NUM_SETS * NUM_WAYS;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic go;     // look up the held request and load the output register
  } cmd_t;

endpackage
`default_nettype wire

FILE: sv/tcl_datapath.sv
// Cache storage, tag compare, FIFO replacement and output register.
`default_nettype none
module tcl_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tcl_pkg::cmd_t                 cmd,
  input  wire logic [tcl_pkg::ADDR_BITS-1:0] address,
  input  wire logic [tcl_pkg::DATA_BITS-1:0] fill_data,
  output logic                               hit,
  output logic [tcl_pkg::DATA_BITS-1:0]      data,
  output logic [tcl_pkg::WAY_BITS-1:0]       way_used,
  output logic [tcl_pkg::SET_BITS-1:0]       set_index
);

  logic [tcl_pkg::ADDR_BITS-1:0] addr_q;
  logic [tcl_pkg::DATA_BITS-1:0] fill_q;

  logic [tcl_pkg::TAG_BITS-1:0]  line_tags  [tcl_pkg::NUM_LINES];
  logic [tcl_pkg::DATA_BITS-1:0] line_bytes [tcl_pkg::NUM_LINES];
  logic [tcl_pkg::NUM_LINES-1:0] line_valid;
  logic [tcl_pkg::NUM_SETS-1:0]  replace_pointer;

  logic [tcl_pkg::SET_BITS-1:0]  set_sel;
  logic [tcl_pkg::TAG_BITS-1:0]  tag_sel;
  logic [tcl_pkg::LINE_BITS-1:0] line0;
  logic [tcl_pkg::LINE_BITS-1:0] line1;
  logic [tcl_pkg::LINE_BITS-1:0] hit_line;
  logic [tcl_pkg::LINE_BITS-1:0] fill_line;
  logic                          match0;
  logic                          match1;
  logic                          any_match;
  logic [tcl_pkg::WAY_BITS-1:0]  hit_way;
  logic [tcl_pkg::WAY_BITS-1:0]  victim_way;

  always_comb begin
    set_sel    = addr_q[tcl_pkg::SET_BITS-1:0];
    tag_sel    = addr_q[tcl_pkg::ADDR_BITS-1:tcl_pkg::SET_BITS];
    line0      = {set_sel, 1'b0};
    line1      = {set_sel, 1'b1};
    match0     = line_valid[line0] && (line_tags[line0] == tag_sel);
    match1     = line_valid[line1] && (line_tags[line1] == tag_sel);
    any_match  = match0 || match1;
    // way 0 wins if both match, which fills never allow
    hit_way    = match0 ? 1'b0 : 1'b1;
    victim_way = replace_pointer[set_sel];
    hit_line   = {set_sel, hit_way};
    fill_line  = {set_sel, victim_way};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= address;
      fill_q <= fill_data;
    end
    if (cmd.go) begin
      hit       <= any_match;
      set_index <= set_sel;
      if (any_match) begin
        data     <= line_bytes[hit_line];
        way_used <= hit_way;
      end else begin
        data                  <= fill_q;
        way_used              <= victim_way;
        line_tags[fill_line]  <= tag_sel;
        line_bytes[fill_line] <= fill_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid      <= '0;
      replace_pointer <= '0;
    end else if (cmd.go && !any_match) begin
      line_valid[fill_line]    <= 1'b1;
      replace_pointer[set_sel] <= ~victim_way;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tcl_ctrl.sv
// Handshake controller: input holding stage and output valid flag.
`default_nettype none
module tcl_ctrl (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  output tcl_pkg::cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  always_comb begin
    out_free = !out_valid || out_ready;
    in_ready = (state == ST_IDLE) || out_free;
    cmd.load = in_valid && in_ready;
    cmd.go   = (state == ST_LOOKUP) && out_free;

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (cmd.go && !cmd.load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.go) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/two_way_cache_lookup_fifo_unit.sv
// Top level of the two-way set-associative byte cache with FIFO replacement.
//
// Requests arrive on in_valid/in_ready carrying address and fill_data, the
// backing memory byte at that address. Results leave on out_valid/out_ready
// as hit, data, way_used and set_index, one result per request, in order.
// The set is the low address bits, the tag the remaining bits; both ways of
// the set are compared against the tag together with their valid bits.
// On a miss the way named by the set's replacement pointer takes the tag and
// byte, becomes valid, the pointer toggles, and the fill byte is returned.
// A request accepted into the holding register is looked up and its result
// loaded into the output register once that register is free to take it.
// Throughput: one request per cycle while the receiver takes results, set by
// the single holding register ahead of the tag compare and the output register.
// When the receiver stalls, the output register holds its result, at most one
// more request is taken into an empty holding register, and in_ready then drops.
// Reset clears all valid bits and replacement pointers at once and empties
// both the holding register and the output register; no clearing pass.
`default_nettype none
module two_way_cache_lookup_fifo_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tcl_pkg::ADDR_BITS-1:0] address,
  input  wire logic [tcl_pkg::DATA_BITS-1:0] fill_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic [tcl_pkg::DATA_BITS-1:0]      data,
  output logic [tcl_pkg::WAY_BITS-1:0]       way_used,
  output logic [tcl_pkg::SET_BITS-1:0]       set_index
);

  tcl_pkg::cmd_t cmd;

  tcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tcl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .address   (address),
    .fill_data (fill_data),
    .hit       (hit),
    .data      (data),
    .way_used  (way_used),
    .set_index (set_index)
  );

endmodule
`default_nettype wire

FILE: sv/tcl_checker.sv
// Port-level checks for the cache lookup block, bound to its top level.
`default_nettype none
module tcl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [tcl_pkg::ADDR_BITS-1:0] address,
  input wire logic [tcl_pkg::DATA_BITS-1:0] fill_data,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          hit,
  input wire logic [tcl_pkg::DATA_BITS-1:0] data,
  input wire logic [tcl_pkg::WAY_BITS-1:0]  way_used,
  input wire logic [tcl_pkg::SET_BITS-1:0]  set_index
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(data)
      && $stable(way_used) && $stable(set_index))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // an accepted request is followed by a valid result (its own, or one already stalled)
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result two cycles after request");

  // the input side only backs up when the output side is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // a waiting request keeps its payload until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(address) && $stable(fill_data))
    else $error("request changed while waiting");

endmodule

bind two_way_cache_lookup_fifo_unit tcl_checker u_tcl_checker (.*);
`default_nettype wire
